// ===== hw/rtl/bbg_pkg.sv =====
`default_nettype none

package bbg_pkg;

  // box checks
  localparam int HALF_WIDTH = 320;
  localparam int MIN_SIDE   = 10;
  localparam int MAX_SIDE   = 100;
  localparam int MAX_RATIO  = 3;

  // datapath widths
  localparam int COORD_W   = 16;
  localparam int SIDE_W    = COORD_W + 1;
  localparam int RAT_W     = COORD_W + $clog2(MAX_RATIO + 2);
  localparam int XC_W      = COORD_W + 2;
  localparam int YC_W      = COORD_W + 1;
  localparam int PROD_W    = 2 * XC_W;
  localparam int COEFQ_W   = 24;
  localparam int COEFL_W   = 35;
  localparam int COEFK_W   = 42;
  localparam int QT_W      = COEFQ_W + PROD_W;
  localparam int LT_W      = COEFL_W + XC_W;
  localparam int SUM_W     = 58;
  localparam int FRAC_CUT  = 24;
  localparam int RES_W     = SUM_W - FRAC_CUT;
  localparam int OUT_W     = 32;

  // register stages from accept to result
  localparam int PIPE_D = 5;

  localparam logic signed [SIDE_W-1:0] MIN_SIDE_S   = SIDE_W'(MIN_SIDE);
  localparam logic signed [SIDE_W-1:0] MAX_SIDE_S   = SIDE_W'(MAX_SIDE);
  localparam logic [RAT_W-1:0]         RATIO_LIM    = RAT_W'(MAX_RATIO + 1);
  localparam logic [XC_W-1:0]          HALF_WIDTH_U = XC_W'(HALF_WIDTH);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF   = SUM_W'(64'sd1 <<< (FRAC_CUT - 1));
  localparam logic signed [RES_W-1:0]  OUT_MAX_S    = RES_W'(64'sd2147483647);
  localparam logic signed [RES_W-1:0]  OUT_MIN_S    = RES_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_RATIO = 2'd2
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic signed [XC_W-1:0]   xc;
    logic signed [YC_W-1:0]   yc;
  } front_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] xy;
    logic signed [XC_W-1:0]   xc;
    logic signed [YC_W-1:0]   yc;
  } square_t;

  typedef struct packed {
    logic signed [COEFQ_W-1:0] q_xx;
    logic signed [COEFQ_W-1:0] q_yy;
    logic signed [COEFQ_W-1:0] q_xy;
    logic signed [COEFL_W-1:0] l_x;
    logic signed [COEFL_W-1:0] l_y;
    logic signed [COEFK_W-1:0] k;
  } coef_set_t;

  // calibration coefficients, 32 fraction bits
  localparam coef_set_t GX_COEF = '{
    q_xx: -24'sd114998,
    q_yy:  24'sd155580,
    q_xy: -24'sd221178,
    l_x:   35'sd1210543288,
    l_y:  -35'sd1201929298,
    k:     42'sd228411510897
  };

  localparam coef_set_t GY_COEF = '{
    q_xx:  24'sd180154,
    q_yy:  24'sd5228711,
    q_xy:  24'sd134918,
    l_x:  -35'sd37949641,
    l_y:  -35'sd5664227358,
    k:     42'sd1639022942825
  };

endpackage

`default_nettype wire

// ===== hw/rtl/bbg_front.sv =====
`default_nettype none

module bbg_front (
  input  wire logic                          clk,
  input  wire logic [bbg_pkg::COORD_W-1:0]   left_x,
  input  wire logic [bbg_pkg::COORD_W-1:0]   top_y,
  input  wire logic [bbg_pkg::COORD_W-1:0]   right_x,
  input  wire logic [bbg_pkg::COORD_W-1:0]   bottom_y,
  output bbg_pkg::front_t                    front_r
);

  logic signed [bbg_pkg::SIDE_W-1:0] w_s;
  logic signed [bbg_pkg::SIDE_W-1:0] h_s;
  logic [bbg_pkg::RAT_W-1:0]         w_u;
  logic [bbg_pkg::RAT_W-1:0]         h_u;
  logic                              size_ok;
  logic                              ratio_bad;
  bbg_pkg::front_t                   front_nxt;

  assign w_s = $signed({1'b0, right_x}) - $signed({1'b0, left_x});
  assign h_s = $signed({1'b0, bottom_y}) - $signed({1'b0, top_y});

  assign size_ok = (w_s >= bbg_pkg::MIN_SIDE_S) && (w_s <= bbg_pkg::MAX_SIDE_S) &&
                   (h_s >= bbg_pkg::MIN_SIDE_S) && (h_s <= bbg_pkg::MAX_SIDE_S);

  // integer quotient above the limit means side >= (limit + 1) * other side
  assign w_u = bbg_pkg::RAT_W'(w_s[bbg_pkg::COORD_W-1:0]);
  assign h_u = bbg_pkg::RAT_W'(h_s[bbg_pkg::COORD_W-1:0]);
  assign ratio_bad = (w_u >= bbg_pkg::RATIO_LIM * h_u) ||
                     (h_u >= bbg_pkg::RATIO_LIM * w_u);

  always_comb begin
    priority if (!size_ok) begin
      front_nxt.status = bbg_pkg::ST_SIZE;
    end else if (ratio_bad) begin
      front_nxt.status = bbg_pkg::ST_RATIO;
    end else begin
      front_nxt.status = bbg_pkg::ST_OK;
    end
    front_nxt.xc = $signed(bbg_pkg::XC_W'(left_x) +
                           bbg_pkg::XC_W'(w_s[bbg_pkg::COORD_W-1:1]) -
                           bbg_pkg::HALF_WIDTH_U);
    front_nxt.yc = $signed({1'b0, bottom_y});
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbg_square.sv =====
`default_nettype none

module bbg_square (
  input  wire logic             clk,
  input  wire bbg_pkg::front_t  front_i,
  output bbg_pkg::square_t      sq_r
);

  bbg_pkg::square_t sq_nxt;

  always_comb begin
    sq_nxt.xx = bbg_pkg::PROD_W'(front_i.xc) * bbg_pkg::PROD_W'(front_i.xc);
    sq_nxt.yy = bbg_pkg::PROD_W'(front_i.yc) * bbg_pkg::PROD_W'(front_i.yc);
    sq_nxt.xy = bbg_pkg::PROD_W'(front_i.xc) * bbg_pkg::PROD_W'(front_i.yc);
    sq_nxt.xc = front_i.xc;
    sq_nxt.yc = front_i.yc;
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbg_poly.sv =====
`default_nettype none

module bbg_poly (
  input  wire logic                              clk,
  input  wire bbg_pkg::coef_set_t                coef,
  input  wire bbg_pkg::square_t                  sq_i,
  output logic signed [bbg_pkg::OUT_W-1:0]       pos_r
);

  // coefficient products
  logic signed [bbg_pkg::QT_W-1:0]  t_xx_r, t_yy_r, t_xy_r;
  logic signed [bbg_pkg::LT_W-1:0]  t_x_r, t_y_r;
  // partial sums
  logic signed [bbg_pkg::SUM_W-1:0] pa_r, pb_r;
  logic signed [bbg_pkg::SUM_W-1:0] pa_nxt, pb_nxt;
  // final add, round, clamp
  logic signed [bbg_pkg::SUM_W-1:0] sum_rnd;
  logic signed [bbg_pkg::RES_W-1:0] res;
  logic signed [bbg_pkg::OUT_W-1:0] pos_nxt;

  always_ff @(posedge clk) begin
    t_xx_r <= bbg_pkg::QT_W'(coef.q_xx) * bbg_pkg::QT_W'(sq_i.xx);
    t_yy_r <= bbg_pkg::QT_W'(coef.q_yy) * bbg_pkg::QT_W'(sq_i.yy);
    t_xy_r <= bbg_pkg::QT_W'(coef.q_xy) * bbg_pkg::QT_W'(sq_i.xy);
    t_x_r  <= bbg_pkg::LT_W'(coef.l_x) * bbg_pkg::LT_W'(sq_i.xc);
    t_y_r  <= bbg_pkg::LT_W'(coef.l_y) * bbg_pkg::LT_W'(sq_i.yc);
  end

  assign pa_nxt = bbg_pkg::SUM_W'(t_xx_r) + bbg_pkg::SUM_W'(t_yy_r) +
                  bbg_pkg::SUM_W'(t_xy_r);
  assign pb_nxt = bbg_pkg::SUM_W'(t_x_r) + bbg_pkg::SUM_W'(t_y_r) +
                  bbg_pkg::SUM_W'(coef.k);

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
  end

  // round half up to 8 fraction bits, then clamp to 32 bits
  assign sum_rnd = pa_r + pb_r + bbg_pkg::ROUND_HALF;
  assign res     = bbg_pkg::RES_W'(sum_rnd >>> bbg_pkg::FRAC_CUT);

  always_comb begin
    priority if (res > bbg_pkg::OUT_MAX_S) begin
      pos_nxt = bbg_pkg::OUT_W'(bbg_pkg::OUT_MAX_S);
    end else if (res < bbg_pkg::OUT_MIN_S) begin
      pos_nxt = bbg_pkg::OUT_W'(bbg_pkg::OUT_MIN_S);
    end else begin
      pos_nxt = bbg_pkg::OUT_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbox_to_ground_position_core.sv =====
// bounding box to ground position mapper
//
// input: one box per transaction on in_left_x, in_top_y, in_right_x and
//   in_bottom_y, taken at a rising edge with start high and busy low
// output: out_status, out_ground_x and out_ground_y, shown for exactly one
//   cycle with out_valid high; rejected boxes carry zero coordinates
// pipeline: from the accepting edge to the out_valid cycle a box passes
//   box check, squares, coefficient multipliers, partial sums and final
//   add with rounding and clamp, one register stage each
// throughput: one box per cycle, back to back, without bubbles
// busy is high only while rst_n is low; no other condition holds off start
// reset: synchronous, active low; clears the valid pipeline so nothing
//   emerges from transactions taken before or during reset
// the receiver cannot stall: each result is taken in its cycle, so the
//   pipeline never holds and never drops or repeats a transaction
`default_nettype none

module bbox_to_ground_position_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bbg_pkg::COORD_W-1:0]    in_left_x,
  input  wire logic [bbg_pkg::COORD_W-1:0]    in_top_y,
  input  wire logic [bbg_pkg::COORD_W-1:0]    in_right_x,
  input  wire logic [bbg_pkg::COORD_W-1:0]    in_bottom_y,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [bbg_pkg::OUT_W-1:0]    out_ground_x,
  output logic signed [bbg_pkg::OUT_W-1:0]    out_ground_y
);

  logic                              accept;
  logic [bbg_pkg::PIPE_D-1:0]        vld_r;
  logic [bbg_pkg::PIPE_D-1:0]        vld_nxt;
  bbg_pkg::status_t                  st_r [bbg_pkg::PIPE_D-1];
  bbg_pkg::front_t                   front;
  bbg_pkg::square_t                  sq;
  logic signed [bbg_pkg::OUT_W-1:0]  gx;
  logic signed [bbg_pkg::OUT_W-1:0]  gy;
  logic                              rejected;

  // only reset holds off a transaction
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // stage 1: size and aspect checks, center x and bottom y
  bbg_front u_front (
    .clk      (clk),
    .left_x   (in_left_x),
    .top_y    (in_top_y),
    .right_x  (in_right_x),
    .bottom_y (in_bottom_y),
    .front_r  (front)
  );

  // stage 2: xc*xc, yc*yc, xc*yc
  bbg_square u_square (
    .clk     (clk),
    .front_i (front),
    .sq_r    (sq)
  );

  // stages 3 to 5: one polynomial per output coordinate
  bbg_poly u_poly_x (
    .clk   (clk),
    .coef  (bbg_pkg::GX_COEF),
    .sq_i  (sq),
    .pos_r (gx)
  );

  bbg_poly u_poly_y (
    .clk   (clk),
    .coef  (bbg_pkg::GY_COEF),
    .sq_i  (sq),
    .pos_r (gy)
  );

  // valid bits move with the data, one per stage
  assign vld_nxt = {vld_r[bbg_pkg::PIPE_D-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // status rides alongside the arithmetic from stage 2 onward
  always_ff @(posedge clk) begin
    st_r[0] <= front.status;
    for (int i = 1; i < bbg_pkg::PIPE_D - 1; i++) begin
      st_r[i] <= st_r[i-1];
    end
  end

  assign rejected     = (st_r[bbg_pkg::PIPE_D-2] != bbg_pkg::ST_OK);
  assign out_valid    = vld_r[bbg_pkg::PIPE_D-1];
  assign out_status   = st_r[bbg_pkg::PIPE_D-2];
  // rejected boxes report the origin
  assign out_ground_x = rejected ? '0 : gx;
  assign out_ground_y = rejected ? '0 : gy;

`ifndef SYNTHESIS
  // every accepted transaction yields a result after the pipeline depth
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted box produced no result");

  // no result without a transaction accepted at the matching edge
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result without accepted box");

  // reset empties the pipeline
  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // a rejected box never leaks polynomial values
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bbg_pkg::ST_OK) |->
      (out_ground_x == '0 && out_ground_y == '0))
    else $error("rejected box with nonzero position");
`endif

endmodule

`default_nettype wire
